// ===== rtl/slcan_efp_pkg.sv =====
`timescale 1ns / 1ps

package slcan_efp_pkg;

  localparam logic [7:0]  CharCr      = 8'h0D;
  localparam logic [7:0]  CharT       = 8'h54;
  localparam logic [7:0]  CharZero    = 8'h30;
  localparam int unsigned IdPosLast   = 8;
  localparam int unsigned LenPos      = 9;
  localparam int unsigned MinLine     = 10;
  localparam int unsigned MaxLen      = 8;
  localparam int unsigned DataNibbles = 2 * MaxLen;
  localparam int unsigned DataPosEnd  = MinLine + DataNibbles;
  localparam logic [31:0] IdMask      = 32'h1FFF_FFFF;

  // One decoded frame as it travels from the decoder to the result register.
  typedef struct packed {
    logic [28:0]           frame_id;
    logic [3:0]            frame_length;
    logic [MaxLen-1:0][7:0] data;
  } frame_t;

  // ASCII hex digit to nibble; anything that is not a hex digit reads as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] ch);
    logic [3:0] v;
    v = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      v = 4'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      v = 4'(ch - 8'h37);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      v = 4'(ch - 8'h57);
    end
    return v;
  endfunction

endpackage

// ===== rtl/slcan_efp_in_reg.sv =====
`timescale 1ns / 1ps

module slcan_efp_in_reg import slcan_efp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  output logic       ready_o,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  // The register refills in the same cycle that its beat is consumed.
  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== rtl/slcan_efp_decode.sv =====
`timescale 1ns / 1ps

module slcan_efp_decode import slcan_efp_pkg::*; #(
  parameter int unsigned LINE_BUFFER_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] byte_i,
  input  logic       step_i,
  output logic       fire_o,
  output frame_t     frame_o
);

  localparam int unsigned CntW = $clog2(LINE_BUFFER_DEPTH);
  localparam int unsigned PosW = (CntW > 5) ? CntW : 5;
  localparam logic [CntW-1:0] LastCount = CntW'(LINE_BUFFER_DEPTH - 1);

  logic [CntW-1:0]             count_q, count_d;
  logic                        start_t_q, start_t_d;
  logic [31:0]                 id_q, id_d;
  logic [7:0]                  len_q, len_d;
  logic [DataNibbles-1:0][3:0] data_q, data_d;

  logic [PosW-1:0] pos;
  logic [3:0]      nib;
  logic [3:0]      k;
  logic [4:0]      needed;
  logic            is_cr;
  logic            len_ok;
  logic            line_ok;

  assign pos    = PosW'(count_q);
  assign nib    = hex_value(byte_i);
  assign k      = 4'(pos - PosW'(MinLine));
  assign is_cr  = (byte_i == CharCr);
  assign len_ok = (len_q <= 8'(MaxLen));
  assign needed = 5'(MinLine) + {len_q[3:0], 1'b0};

  assign line_ok = start_t_q && (pos >= PosW'(MinLine)) && len_ok &&
                   (pos >= PosW'(needed));
  assign fire_o  = is_cr && (count_q != '0) && line_ok;

  always_comb begin
    count_d   = count_q;
    start_t_d = start_t_q;
    id_d      = id_q;
    len_d     = len_q;
    data_d    = data_q;
    if (is_cr) begin
      count_d = '0;
    end else if (count_q < LastCount) begin
      count_d = count_q + 1'b1;
      if (pos == '0) begin
        start_t_d = (byte_i == CharT);
        id_d      = '0;
      end else if (pos <= PosW'(IdPosLast)) begin
        id_d = {id_q[27:0], nib};
      end else if (pos == PosW'(LenPos)) begin
        len_d = byte_i - CharZero;
      end else if (pos < PosW'(DataPosEnd)) begin
        // The high nibble of each byte arrives first.
        for (int j = 0; j < DataNibbles; j++) begin
          if (4'(j) == (k ^ 4'd1)) begin
            data_d[j] = nib;
          end
        end
      end
    end else begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      start_t_q <= 1'b0;
    end else if (step_i) begin
      count_q   <= count_d;
      start_t_q <= start_t_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      id_q   <= id_d;
      len_q  <= len_d;
      data_q <= data_d;
    end
  end

  always_comb begin
    frame_o.frame_id     = 29'(id_q & IdMask);
    frame_o.frame_length = len_q[3:0];
    for (int i = 0; i < MaxLen; i++) begin
      frame_o.data[i] = (8'(i) < len_q) ? {data_q[2*i+1], data_q[2*i]} : 8'd0;
    end
  end

endmodule

// ===== rtl/slcan_efp_out_reg.sv =====
`timescale 1ns / 1ps

module slcan_efp_out_reg import slcan_efp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  frame_t frame_i,
  output logic   free_o,
  output logic   valid_o,
  input  logic   ready_i,
  output frame_t frame_o
);

  logic   valid_q, valid_d;
  frame_t frame_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= frame_i;
    end
  end

  assign valid_o = valid_q;
  assign frame_o = frame_q;

endmodule

// ===== rtl/slcan_extended_frame_parser_top.sv =====
`timescale 1ns / 1ps

// SLCAN extended-frame parser. Received ASCII bytes enter one beat at a time
// and are decoded on the fly into an identifier, a length code and sixteen
// data nibbles; no line buffer is kept. A carriage return that ends a
// non-empty line of the form T<8 hex id><length digit><hex pairs> yields one
// output beat with the 29-bit identifier, the length (0 to 8) and eight data
// bytes, those at or beyond the length reading as zero. Lines that do not
// start with T, are shorter than ten characters, carry a length digit above
// 8 or lack data pairs are dropped silently; bad hex digits read as zero and
// characters past the needed pairs are ignored. A line that reaches
// LINE_BUFFER_DEPTH-1 characters drops the next byte and restarts at the
// first position. A byte waits in the input register while the decoder folds
// it into the running state, so a byte can be taken in every cycle; only a
// decoded frame that finds the output register still occupied holds the
// input side back. A carriage return reaches the output beat through the
// input register and then the output register.
module slcan_extended_frame_parser_top import slcan_efp_pkg::*; #(
  parameter int unsigned LINE_BUFFER_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [28:0] frame_id_o,
  output logic [3:0]  frame_length_o,
  output logic [7:0]  byte_zero_o,
  output logic [7:0]  byte_one_o,
  output logic [7:0]  byte_two_o,
  output logic [7:0]  byte_three_o,
  output logic [7:0]  byte_four_o,
  output logic [7:0]  byte_five_o,
  output logic [7:0]  byte_six_o,
  output logic [7:0]  byte_seven_o
);

  logic       byte_valid;
  logic [7:0] byte_held;
  logic       step;
  logic       fire;
  logic       out_free;
  frame_t     frame_dec;
  frame_t     frame_out;

  // The held byte is consumed unless it completes a frame and the output
  // register cannot take that frame in this cycle.
  assign step = byte_valid && (!fire || out_free);

  slcan_efp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .byte_i  (rx_byte_i),
    .ready_o (in_ready_o),
    .take_i  (step),
    .valid_o (byte_valid),
    .byte_o  (byte_held)
  );

  slcan_efp_decode #(
    .LINE_BUFFER_DEPTH (LINE_BUFFER_DEPTH)
  ) u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_held),
    .step_i  (step),
    .fire_o  (fire),
    .frame_o (frame_dec)
  );

  slcan_efp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && fire),
    .frame_i (frame_dec),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .frame_o (frame_out)
  );

  assign frame_id_o     = frame_out.frame_id;
  assign frame_length_o = frame_out.frame_length;
  assign byte_zero_o    = frame_out.data[0];
  assign byte_one_o     = frame_out.data[1];
  assign byte_two_o     = frame_out.data[2];
  assign byte_three_o   = frame_out.data[3];
  assign byte_four_o    = frame_out.data[4];
  assign byte_five_o    = frame_out.data[5];
  assign byte_six_o     = frame_out.data[6];
  assign byte_seven_o   = frame_out.data[7];

  // An emitted frame never claims more than eight data bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_length_o <= 4'(MaxLen))
    else $error("frame length above eight");

  // A frame shorter than eight bytes has byte seven at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_length_o < 4'(MaxLen)) |-> byte_seven_o == 8'd0)
    else $error("byte beyond frame length not cleared");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_length_o == 4'd0) |-> byte_zero_o == 8'd0)
    else $error("empty frame carries data");

  // The input side only stalls while a finished frame waits for a full
  // output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (byte_valid && fire && out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked frame");

endmodule

// ===== test/slcan_frame_compare.sv =====
`timescale 1ns / 1ps

// Watches both channels of the parser. It rebuilds each frame from the bytes
// that go in and checks every output beat against the oldest frame still due.
module slcan_frame_compare import slcan_efp_pkg::*; #(
  parameter int unsigned LINE_BUFFER_DEPTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [7:0]             rx_byte_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [28:0]            frame_id_i,
  input  logic [3:0]             frame_length_i,
  input  logic [MaxLen-1:0][7:0] frame_data_i,
  output int unsigned            mismatches_o,
  output int unsigned            frames_pending_o
);

  int unsigned line_len;
  logic        line_is_t;
  logic [31:0] id_nibbles;
  logic [7:0]  len_code;
  logic [63:0] data_nibbles;
  frame_t      frames_due[$];
  int unsigned mismatch_count;

  // The low nibble of a hex letter is its value minus nine.
  function automatic logic [3:0] nibble_of(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return ch[3:0];
    if ((ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f")) return ch[3:0] + 4'd9;
    return 4'd0;
  endfunction

  function automatic void flag(input string what, input longint unsigned want,
                               input longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
  endfunction

  task automatic take_byte(input logic [7:0] ch);
    int unsigned k;
    logic        ok;
    frame_t      f;
    if (ch != CharCr) begin
      if (line_len < LINE_BUFFER_DEPTH - 1) begin
        if (line_len == 0) begin
          line_is_t  = (ch == CharT);
          id_nibbles = '0;
        end else if (line_len <= IdPosLast) begin
          id_nibbles = {id_nibbles[27:0], nibble_of(ch)};
        end else if (line_len == LenPos) begin
          len_code = ch - CharZero;
        end else if (line_len < DataPosEnd) begin
          // Even data positions carry the high nibble of their byte.
          k = line_len - MinLine;
          data_nibbles[8 * (k / 2) + ((k % 2 == 0) ? 4 : 0) +: 4] = nibble_of(ch);
        end
        line_len++;
      end else begin
        // The line ran full: this byte is lost and a new line begins.
        line_len = 0;
      end
    end else if (line_len != 0) begin
      ok = line_is_t && line_len >= MinLine && len_code <= MaxLen &&
           line_len >= MinLine + 2 * len_code;
      line_len = 0;
      if (ok) begin
        f.frame_id     = id_nibbles[28:0];
        f.frame_length = len_code[3:0];
        for (int i = 0; i < MaxLen; i++) begin
          f.data[i] = (i < len_code) ? data_nibbles[8 * i +: 8] : 8'h00;
        end
        frames_due = {frames_due, f};
      end
    end
  endtask

  task automatic check_beat();
    frame_t want;
    if (frames_due.size() == 0) begin
      flag("unexpected frame, id", 0, frame_id_i);
    end else begin
      want = frames_due.pop_front();
      if (frame_id_i !== want.frame_id) flag("frame_id", want.frame_id, frame_id_i);
      if (frame_length_i !== want.frame_length) begin
        flag("frame_length", want.frame_length, frame_length_i);
      end
      for (int i = 0; i < MaxLen; i++) begin
        if (frame_data_i[i] !== want.data[i]) begin
          flag($sformatf("data byte %0d", i), want.data[i], frame_data_i[i]);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len       = 0;
      line_is_t      = 1'b0;
      id_nibbles     = '0;
      len_code       = '0;
      data_nibbles   = '0;
      mismatch_count = 0;
      frames_due.delete();
      mismatches_o     <= 0;
      frames_pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_beat();
      if (in_valid_i && in_ready_i) take_byte(rx_byte_i);
      mismatches_o     <= mismatch_count;
      frames_pending_o <= frames_due.size();
    end
  end

endmodule

// ===== test/slcan_extended_frame_parser_top_tb.sv =====
`timescale 1ns / 1ps

// Top of the parser testbench. It feeds ASCII bytes into the parser, drives
// the output ready, and gives the verdict. All prediction and comparison is
// done by the frame compare module that sits beside the parser.
module slcan_extended_frame_parser_top_tb;
  import slcan_efp_pkg::*;

  localparam int unsigned LineDepth   = 32;
  // Stimulus stops once this many bytes went in.
  localparam int unsigned ByteTarget  = 850;
  // Cycles without any beat on either channel before the run is given up.
  // Gaps and stalls are random with at most a 51 percent chance per cycle,
  // so a real run never comes near this.
  localparam int unsigned StallLimit  = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [28:0] frame_id_o;
  logic [3:0]  frame_length_o;
  logic [7:0]  byte_zero_o;
  logic [7:0]  byte_one_o;
  logic [7:0]  byte_two_o;
  logic [7:0]  byte_three_o;
  logic [7:0]  byte_four_o;
  logic [7:0]  byte_five_o;
  logic [7:0]  byte_six_o;
  logic [7:0]  byte_seven_o;

  int unsigned mismatches;
  int unsigned frames_pending;
  int unsigned bytes_sent;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;

  always #5 clk_i = ~clk_i;

  slcan_extended_frame_parser_top #(
    .LINE_BUFFER_DEPTH(LineDepth)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_id_o    (frame_id_o),
    .frame_length_o(frame_length_o),
    .byte_zero_o   (byte_zero_o),
    .byte_one_o    (byte_one_o),
    .byte_two_o    (byte_two_o),
    .byte_three_o  (byte_three_o),
    .byte_four_o   (byte_four_o),
    .byte_five_o   (byte_five_o),
    .byte_six_o    (byte_six_o),
    .byte_seven_o  (byte_seven_o)
  );

  slcan_frame_compare #(
    .LINE_BUFFER_DEPTH(LineDepth)
  ) u_compare (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_id_i      (frame_id_o),
    .frame_length_i  (frame_length_o),
    .frame_data_i    ({byte_seven_o, byte_six_o, byte_five_o, byte_four_o,
                       byte_three_o, byte_two_o, byte_one_o, byte_zero_o}),
    .mismatches_o    (mismatches),
    .frames_pending_o(frames_pending)
  );

  // The output side drops ready at random, as often as the current phase
  // asks. With stall_pct at zero ready stays high.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: a lost frame or a hung handshake shows up as a long stretch
  // with no beat on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Watchdog: no beat for %0d cycles", StallLimit);
      $display("** slcan_extended_frame_parser_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] rand_non_cr();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CharCr);
    return b;
  endfunction

  // Mostly a valid hex digit in either case; now and then any byte but a
  // carriage return, which the parser must read as a zero nibble if not hex.
  function automatic logic [7:0] rand_hex_char();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 19) == 0) return rand_non_cr();
    if (v < 10) return 8'(CharZero + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  // Sends one byte. Before it, the sender may sit idle as the phase asks;
  // once valid is up it stays up until the beat is taken.
  task automatic send_beat(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i]);
  endtask

  // One line in the shape lead, eight id digits, length character, a number
  // of data digits and some trailing bytes, with or without its carriage
  // return. The caller bends the pieces to make good and broken lines.
  task automatic send_line(input logic [7:0] lead, input logic [7:0] len_char,
                           input int unsigned nibbles, input int unsigned trail,
                           input bit end_cr);
    send_beat(lead);
    repeat (8) send_beat(rand_hex_char());
    send_beat(len_char);
    repeat (nibbles) send_beat(rand_hex_char());
    repeat (trail) send_beat(rand_non_cr());
    if (end_cr) send_beat(CharCr);
  endtask

  initial begin
    int unsigned kind;
    int unsigned len;
    int unsigned total;
    int unsigned phase;

    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    rx_byte_i    <= 8'h00;
    stall_pct    <= 0;
    idle_pct     = 0;
    bytes_sent   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. An empty line must do nothing.
    send_beat(CharCr);
    // All-ones identifier in lower case, which the mask cuts to 29 bits,
    // and a one-byte frame whose two data digits are not hex.
    send_text("Tffffffff1zz");
    send_beat(CharCr);
    // The extreme byte values in a line that does not start with T.
    send_beat(8'h00);
    send_beat(8'hFF);
    send_beat(CharCr);
    // A line far too short to hold an identifier.
    send_text("T0");
    send_beat(CharCr);

    // Random part, in four phases of idling: none, sender gaps, receiver
    // stalls, then both at a lower rate.
    while (bytes_sent < ByteTarget) begin
      phase = bytes_sent * 4 / ByteTarget;
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 51;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 51;
        end
        default: begin
          idle_pct = 17;
          stall_pct <= 17;
        end
      endcase

      kind = $urandom_range(0, 99);
      len  = $urandom_range(0, MaxLen);
      if (kind < 60) begin
        // Well-formed frame, sometimes with trailing bytes after the data.
        send_line(CharT, 8'(CharZero + len), 2 * len,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, 1'b1);
      end else if (kind < 68) begin
        // Length character out of range: a nine, or any byte, which covers
        // characters below the digit zero that wrap to large values.
        send_line(CharT, ($urandom_range(0, 1) ? 8'(CharZero + 9) : rand_non_cr()),
                  $urandom_range(0, 18), 0, 1'b1);
      end else if (kind < 75) begin
        // Too few data digits for the given length.
        len = $urandom_range(1, MaxLen);
        send_line(CharT, 8'(CharZero + len), $urandom_range(0, 2 * len - 1), 0, 1'b1);
      end else if (kind < 80) begin
        // Ends before the length character.
        send_beat(CharT);
        repeat ($urandom_range(0, 8)) send_beat(rand_hex_char());
        send_beat(CharCr);
      end else if (kind < 85) begin
        // Lead character other than T.
        send_line(rand_non_cr(), 8'(CharZero + len), 2 * len, 0, 1'b1);
      end else if (kind < 91) begin
        // Lines around the buffer depth. Without the carriage return a
        // line of exactly the depth loses its last byte, and the next line
        // starts cleanly at the first position.
        total = $urandom_range(LineDepth - 3, LineDepth + 2);
        send_line(CharT, 8'(CharZero + len), 2 * len, total - MinLine - 2 * len,
                  1'($urandom_range(0, 1)));
      end else if (kind < 96) begin
        // Noise, carriage returns included.
        repeat ($urandom_range(1, 12)) send_beat(8'($urandom_range(0, 255)));
      end else begin
        send_beat(CharCr);
      end
    end
    in_valid_i <= 1'b0;

    // Wait until every predicted frame came out, then keep running so that
    // a spurious extra frame would still be seen.
    do @(posedge clk_i); while (frames_pending != 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && frames_pending == 0) begin
      $display("** slcan_extended_frame_parser_top: PASSED **");
    end else begin
      $display("** slcan_extended_frame_parser_top: FAILED **");
    end
    $finish;
  end

endmodule
